FILE: design/fsl_pkg.sv
// Package for the per-source flood limiter: payload widths, register map,
// flood level codes, configuration and job structs, scan engine states.
// No dependencies.
package fsl_pkg;

    localparam int SRC_W      = 32;  // source address field
    localparam int TIME_W     = 48;  // millisecond timestamps
    localparam int WIN_W      = 26;  // period_seconds * 1000 fits in 26 bits
    localparam int MS_PER_S   = 1000;
    localparam int APB_ADDR_W = 4;   // three 32-bit registers at 0x0, 0x4, 0x8
    localparam int APB_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  MINOR_RESET  = 8'd5;
    localparam logic [7:0]  SEVERE_RESET = 8'd10;
    localparam logic [15:0] PERIOD_RESET = 16'd60;

    // register index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_MINOR  = 2'd0,
        REG_SEVERE = 2'd1,
        REG_PERIOD = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        LVL_OK     = 2'd0,
        LVL_MINOR  = 2'd1,
        LVL_SEVERE = 2'd2
    } flood_level_t;

    typedef struct packed {
        logic [7:0]  minor_count;
        logic [7:0]  severe_count;
        logic [15:0] period_seconds;
    } cfg_t;

    // One request as handed from the front end to the scan engine.
    typedef struct packed {
        logic              record;   // query then record
        logic [SRC_W-1:0]  source_address;
        logic [TIME_W-1:0] now_ms;
        logic [WIN_W-1:0]  window;   // expiry window in ms
    } job_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_OUT
    } back_state_t;

endpackage

FILE: design/fsl_ifs.sv
// Channel interfaces of the flood limiter: request channel and result channel,
// each with valid/ready handshake and its payload. Depends on nothing.
interface fsl_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] source_address;
    logic [47:0] now_ms;

    modport source (output valid, kind, source_address, now_ms, input ready);
    modport sink   (input valid, kind, source_address, now_ms, output ready);
endinterface

interface fsl_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] flood_level;
    logic       hit_limit;
    logic       record_dropped;

    modport source (output valid, flood_level, hit_limit, record_dropped, input ready);
    modport sink   (input valid, flood_level, hit_limit, record_dropped, output ready);
endinterface

FILE: design/fsl_front.sv
// Front end of the flood limiter: takes request beats, classifies them and
// works out the expiry window. Depends on fsl_pkg and fsl_req_if.
module fsl_front
    import fsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    fsl_req_if.sink   req,
    output logic      job_valid,
    input  logic      job_ready,
    output job_t      job
);

    logic        vld_reg;
    logic        vld_next;
    job_t        job_reg;
    logic [31:0] win_full;
    logic        take;

    // constant multiply, window = period * 1000 ms
    assign win_full = 32'(cfg.period_seconds) * 32'(MS_PER_S);

    assign req.ready = !vld_reg || job_ready;
    assign take      = req.valid && req.ready;
    assign vld_next  = take || (vld_reg && !job_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg.record         <= req.kind;
            job_reg.source_address <= req.source_address;
            job_reg.now_ms         <= req.now_ms;
            job_reg.window         <= win_full[WIN_W-1:0];
        end
    end

    assign job_valid = vld_reg;
    assign job       = job_reg;

endmodule

FILE: design/fsl_queue.sv
// Short job queue between the front end and the scan engine.
// Depends on fsl_pkg.
module fsl_queue
    import fsl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign push_ready = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: design/fsl_back.sv
// Scan engine of the flood limiter: owns the entry table memory, clears it
// after reset, prunes/counts/finds a free slot per job and drives results.
// Depends on fsl_pkg and fsl_rsp_if.
module fsl_back
    import fsl_pkg::*;
#(
    parameter int MAX_ENTRIES  = 64,
    parameter int ADDRESS_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    output logic      job_ready,
    input  job_t      job,
    fsl_rsp_if.source rsp
);

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > 8) ? CNT_W : 8;
    localparam int ENT_W   = 1 + ADDRESS_BITS + TIME_W;
    localparam int VLD_BIT = ENT_W - 1;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CNT_W-1:0]  idx_reg;       // clear index, then read issue index
    logic              eval_vld_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    job_t              job_reg;
    logic [ENT_W-1:0]  rd_data_reg;
    flood_level_t      level_reg;
    logic              hit_reg;
    logic              drop_reg;

    logic [ENT_W-1:0]  mem [MAX_ENTRIES];

    logic                    issue;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [ENT_W-1:0]        mem_wdata;
    logic                    ent_valid;
    logic [ADDRESS_BITS-1:0] ent_addr;
    logic [TIME_W-1:0]       ent_time;
    logic                    expired;
    logic                    live;
    logic                    match;
    logic [CMP_W-1:0]        cnt_x;
    logic [CMP_W-1:0]        minor_x;
    logic [CMP_W-1:0]        severe_x;
    flood_level_t            level_c;
    logic                    hit_c;

    // entry layout: {valid, address, time}
    assign ent_valid = rd_data_reg[VLD_BIT];
    assign ent_addr  = rd_data_reg[TIME_W +: ADDRESS_BITS];
    assign ent_time  = rd_data_reg[TIME_W-1:0];
    assign expired   = ({1'b0, ent_time} + (TIME_W+1)'(job_reg.window))
                       < {1'b0, job_reg.now_ms};
    assign live      = ent_valid && !expired;
    assign match     = live && (ent_addr == ADDRESS_BITS'(job_reg.source_address));

    // severe checked before minor
    assign cnt_x    = CMP_W'(count_reg);
    assign minor_x  = CMP_W'(cfg.minor_count);
    assign severe_x = CMP_W'(cfg.severe_count);

    always_comb
    begin
        level_c = LVL_OK;
        hit_c   = 1'b0;
        if (cnt_x >= severe_x)
        begin
            level_c = LVL_SEVERE;
            hit_c   = (cnt_x == severe_x);
        end
        else if (cnt_x >= minor_x)
        begin
            level_c = LVL_MINOR;
            hit_c   = (cnt_x == minor_x);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == CNT_W'(MAX_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (eval_vld_reg && (eval_idx_reg == IDX_W'(MAX_ENTRIES - 1)))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        job_ready = 1'b0;
        issue     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = eval_idx_reg;
        mem_wdata = '0;
        rsp.valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:0];
            end
            ST_IDLE:
            begin
                job_ready = 1'b1;
            end
            ST_SCAN:
            begin
                issue  = idx_reg < CNT_W'(MAX_ENTRIES);
                // free an expired slot in place
                mem_we = eval_vld_reg && ent_valid && expired;
            end
            ST_FIN:
            begin
                mem_we    = job_reg.record && free_found_reg;
                mem_waddr = free_idx_reg;
                mem_wdata = {1'b1, ADDRESS_BITS'(job_reg.source_address), job_reg.now_ms};
            end
            ST_OUT:
            begin
                rsp.valid = 1'b1;
            end
            default:
            begin
                job_ready = 1'b0;
            end
        endcase
    end

    assign rsp.flood_level    = level_reg;
    assign rsp.hit_limit      = hit_reg;
    assign rsp.record_dropped = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eval_vld_reg <= issue;
            if (state_reg == ST_CLEAR)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else if (state_reg == ST_IDLE)
            begin
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (eval_vld_reg && !live && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            job_reg   <= job;
            count_reg <= '0;
        end
        if (issue)
        begin
            eval_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (eval_vld_reg)
        begin
            if (match)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (!live && !free_found_reg)
            begin
                free_idx_reg <= eval_idx_reg;
            end
        end
        if (state_reg == ST_FIN)
        begin
            level_reg <= level_c;
            hit_reg   <= hit_c;
            drop_reg  <= job_reg.record && !free_found_reg;
        end
    end

    // entry table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

endmodule

FILE: design/per_source_flood_limiter.sv
// Top level of the per-source flood limiter: APB register block, front end,
// job queue and scan engine. Depends on fsl_pkg, fsl_ifs, fsl_front,
// fsl_queue and fsl_back.
//
// Usage:
//   req  : request beats {kind, source_address, now_ms}. kind 1 records the
//          request after its status is reported, kind 0 only queries.
//   rsp  : one result beat per request {flood_level, hit_limit, record_dropped},
//          in request order.
//   APB  : minor_count at 0x0, severe_count at 0x4, period_seconds at 0x8.
//          pready is tied high; write only while no request is in flight.
// Timing:
//   Each request makes one pass over the entry table through its single read
//   port, one slot per cycle, between the scan engine picking it up and its
//   result beat. The front register and a two-deep queue keep taking request
//   beats while a result waits on a stalled receiver; the scan engine holds
//   the result and starts no new request until the beat is taken.
// Reset:
//   rst_n clears control state and config to defaults (5, 10, 60 s). The
//   table is then swept empty slot by slot; requests queue up in the front
//   end and job queue meanwhile and register writes are taken as usual.
module per_source_flood_limiter
    import fsl_pkg::*;
#(
    parameter int MAX_ENTRIES  = 64,
    parameter int ADDRESS_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    fsl_req_if.sink               req,
    fsl_rsp_if.source             rsp
);

    cfg_t     cfg_reg;
    cfg_reg_t reg_sel;
    logic     cfg_wr;
    logic     fq_valid;
    logic     fq_ready;
    job_t     fq_job;
    logic     qb_valid;
    logic     qb_ready;
    job_t     qb_job;

    // ---------------- register block ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minor_count    <= MINOR_RESET;
            cfg_reg.severe_count   <= SEVERE_RESET;
            cfg_reg.period_seconds <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_MINOR:  cfg_reg.minor_count    <= pwdata[7:0];
                REG_SEVERE: cfg_reg.severe_count   <= pwdata[7:0];
                REG_PERIOD: cfg_reg.period_seconds <= pwdata[15:0];
                default:    cfg_reg <= cfg_reg;   // unmapped, write ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MINOR:  prdata = APB_DATA_W'(cfg_reg.minor_count);
            REG_SEVERE: prdata = APB_DATA_W'(cfg_reg.severe_count);
            REG_PERIOD: prdata = APB_DATA_W'(cfg_reg.period_seconds);
            default:    prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    fsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    fsl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    fsl_back #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .rsp       (rsp)
    );

endmodule

FILE: design/fsl_checker.sv
// Port-level checks for the flood limiter and the bind that attaches them.
// Depends on fsl_pkg and per_source_flood_limiter.
module fsl_checker
    import fsl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic                  pready,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [1:0]            rsp_level,
    input logic                  rsp_hit,
    input logic                  rsp_drop
);

    // stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
            && $stable(rsp_hit) && $stable(rsp_drop))
        else $error("result beat changed while stalled");

    // hit only when some threshold was reached
    a_hit_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> rsp_level != LVL_OK)
        else $error("hit_limit with ok level");

    // table sweep after reset: no result right away
    a_no_rsp_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !rsp_valid)
        else $error("result right after reset");

    // minor_count write reads back
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[3:2] == REG_MINOR)
            ##1 $stable(paddr) |-> prdata[7:0] == $past(pwdata[7:0]))
        else $error("minor_count readback mismatch");

endmodule

bind per_source_flood_limiter fsl_checker u_fsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_level (rsp.flood_level),
    .rsp_hit   (rsp.hit_limit),
    .rsp_drop  (rsp.record_dropped)
);

FILE: tb/sv/per_source_flood_limiter_tb.sv
// Self-checking testbench for the per-source flood limiter: directed and random
// request traffic and APB setup, checked against an in-bench model of the entry
// table. Depends on fsl_pkg, fsl_ifs and the per_source_flood_limiter RTL.
`timescale 1ns / 1ps

module per_source_flood_limiter_tb;
    import fsl_pkg::*;

    localparam int TABLE_SLOTS = 64;

    // kind field of a request beat
    typedef enum logic {
        QUERY_ONLY   = 1'b0,
        QUERY_RECORD = 1'b1
    } request_kind_t;

    typedef struct {
        request_kind_t     kind;
        logic [SRC_W-1:0]  source;
        logic [TIME_W-1:0] now;
    } request_t;

    typedef struct {
        flood_level_t level;
        logic         hit;
        logic         dropped;
    } verdict_t;

    logic clk;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fsl_req_if req_ch ();
    fsl_rsp_if rsp_ch ();

    per_source_flood_limiter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Mirror of the block: limits as last written, plus the entry table.
    // Slots with a clear live bit count as free; their source and stamp go unread.
    // ------------------------------------------------------------------
    logic [7:0]        minor_limit;
    logic [7:0]        severe_limit;
    logic [15:0]       period_s;
    logic              slot_live   [TABLE_SLOTS];
    logic [SRC_W-1:0]  slot_source [TABLE_SLOTS];
    logic [TIME_W-1:0] slot_stamp  [TABLE_SLOTS];

    request_t pending_requests[$];   // beats still to be offered
    verdict_t expected_verdicts[$];  // verdicts owed by the block, oldest first

    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned send_gap;
    int unsigned result_stall;
    logic        hold_off;     // long receiver hold-off, owned by its own process
    logic        calm_flow;    // phase with no idling on either side
    logic [TIME_W-1:0] clock_ms;
    logic [SRC_W-1:0]  hot_sources [3];

    // Prune, count, classify, then record: same order as the block.
    function automatic verdict_t judge_request(request_t r);
        logic [63:0] window_ms;
        int unsigned live_hits;
        int          free_idx;
        verdict_t    v;
        window_ms = 64'(period_s) * 64'(MS_PER_S);
        live_hits = 0;
        free_idx  = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            // no wrap: stamp + window is formed in 64 bits
            if (slot_live[i] && (64'(slot_stamp[i]) + window_ms < 64'(r.now)))
                slot_live[i] = 1'b0;
            if (slot_live[i])
            begin
                if (slot_source[i] == r.source)
                    live_hits++;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        v.level   = LVL_OK;
        v.hit     = 1'b0;
        v.dropped = 1'b0;
        // severe wins over minor; a zero threshold matches any count
        if (live_hits >= severe_limit)
        begin
            v.level = LVL_SEVERE;
            v.hit   = (live_hits == severe_limit);
        end
        else if (live_hits >= minor_limit)
        begin
            v.level = LVL_MINOR;
            v.hit   = (live_hits == minor_limit);
        end
        if (r.kind == QUERY_RECORD)
        begin
            if (free_idx >= 0)
            begin
                slot_live[free_idx]   = 1'b1;
                slot_source[free_idx] = r.source;
                slot_stamp[free_idx]  = r.now;
            end
            else
                v.dropped = 1'b1;   // table full, status still reported
        end
        return v;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_flow)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    task automatic note_mismatch(string field_name, longint got, longint want);
        $display("mismatch on result %0d: %s is %0d, expected %0d",
                 results_seen, field_name, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and quiet inputs from time zero
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = QUERY_ONLY;
        req_ch.source_address = '0;
        req_ch.now_ms         = '0;
        rsp_ch.ready          = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Request driver: offers the head of pending_requests. The verdict is
    // predicted at the edge that takes the beat, so the mirror sees items
    // in exactly the order the block does.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : feed_requests
        request_t head;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                head = pending_requests.pop_front();
                expected_verdicts.push_back(judge_request(head));
                send_gap = next_gap();
            end
            if (req_ch.valid && !req_ch.ready)
                ;   // beat not taken yet: hold everything
            else if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                req_ch.valid          <= 1'b1;
                req_ch.kind           <= pending_requests[0].kind;
                req_ch.source_address <= pending_requests[0].source;
                req_ch.now_ms         <= pending_requests[0].now;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each beat against the oldest verdict and
    // throttles ready with random stalls and the long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        verdict_t    want;
        int unsigned g;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                    note_mismatch("unexpected beat", 1, 0);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (rsp_ch.flood_level !== want.level)
                        note_mismatch("flood_level", rsp_ch.flood_level, want.level);
                    if (rsp_ch.hit_limit !== want.hit)
                        note_mismatch("hit_limit", rsp_ch.hit_limit, want.hit);
                    if (rsp_ch.record_dropped !== want.dropped)
                        note_mismatch("record_dropped", rsp_ch.record_dropped, want.dropped);
                end
                results_seen++;
                g = next_gap();
                if (g > 0)
                begin
                    result_stall = g - 1;
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= !hold_off;
            end
            else if (result_stall > 0)
            begin
                result_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !hold_off;
        end
    end

    // Back-pressure: once traffic is flowing, refuse results for a long
    // stretch while the driver keeps offering, so front and queue fill up.
    initial
    begin : long_hold
        hold_off = 1'b0;
        @(posedge clk);
        while (results_seen < 300 || pending_requests.size() < 8)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (900) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // APB write: setup then access; lands on the access edge with pready.
    // ------------------------------------------------------------------
    task automatic write_register(cfg_reg_t idx, logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MINOR:  minor_limit  = value[7:0];
            REG_SEVERE: severe_limit = value[7:0];
            REG_PERIOD: period_s     = value[15:0];
            default:    ;
        endcase
    endtask

    task automatic apply_limits(logic [7:0] minor, logic [7:0] severe, logic [15:0] period);
        write_register(REG_MINOR, 32'(minor));
        write_register(REG_SEVERE, 32'(severe));
        write_register(REG_PERIOD, 32'(period));
    endtask

    task automatic add_request(request_kind_t kind, logic [SRC_W-1:0] source,
                               logic [TIME_W-1:0] now);
        request_t r;
        r.kind   = kind;
        r.source = source;
        r.now    = now;
        pending_requests.push_back(r);
    endtask

    // Every result in before touching the registers again.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Well-formed traffic: a few busy sources on a mostly forward clock,
    // with stray sources, flushing jumps and the odd step back in time.
    task automatic queue_random_phase(int unsigned count);
        logic [31:0]       window_ms;
        int unsigned       s;
        logic [SRC_W-1:0]  source;
        request_kind_t     kind;
        window_ms   = 32'(period_s) * 32'(MS_PER_S);
        clock_ms    = {16'($urandom_range(0, 65535)), 32'($urandom)};
        calm_flow   = ($urandom_range(0, 3) == 0);
        foreach (hot_sources[i])
            hot_sources[i] = $urandom;
        for (int n = 0; n < count; n++)
        begin
            s = $urandom_range(0, 99);
            if (s < 30)
                ;
            else if (s < 80)
                clock_ms = clock_ms + $urandom_range(0, window_ms / 8 + 1);
            else if (s < 95)
                clock_ms = clock_ms + $urandom_range(0, window_ms + 2);
            else if (s < 98)
                clock_ms = clock_ms + 48'(window_ms) * 2 + $urandom_range(1, 1000);
            else
                clock_ms = clock_ms - $urandom_range(0, window_ms / 2 + 1);
            if ($urandom_range(0, 99) < 88)
                source = hot_sources[$urandom_range(0, 2)];
            else
                source = $urandom;
            kind = ($urandom_range(0, 99) < 60) ? QUERY_RECORD : QUERY_ONLY;
            add_request(kind, source, clock_ms);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [SRC_W-1:0] src_a;
        logic [SRC_W-1:0] src_b;
        mismatch_count = 0;
        results_seen   = 0;
        send_gap       = 0;
        result_stall   = 0;
        calm_flow      = 1'b0;
        minor_limit    = MINOR_RESET;
        severe_limit   = SEVERE_RESET;
        period_s       = PERIOD_RESET;
        foreach (slot_live[i])
            slot_live[i] = 1'b0;
        src_a = '0;
        src_b = '1;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Directed: thresholds 1/2, one second window.
        apply_limits(8'd1, 8'd2, 16'd1);
        add_request(QUERY_ONLY,   src_a, 48'd100);   // empty table: ok
        add_request(QUERY_RECORD, src_a, 48'd100);
        add_request(QUERY_ONLY,   src_a, 48'd100);   // count 1: minor, on the limit
        add_request(QUERY_RECORD, src_a, 48'd100);
        add_request(QUERY_ONLY,   src_a, 48'd100);   // count 2: severe, on the limit
        add_request(QUERY_RECORD, src_a, 48'd100);
        add_request(QUERY_ONLY,   src_a, 48'd100);   // count 3: severe, past it
        add_request(QUERY_ONLY,   src_b, 48'd100);   // other source: ok
        add_request(QUERY_RECORD, src_b, 48'd1100);
        add_request(QUERY_ONLY,   src_a, 48'd1100);  // stamp + window == now: still live
        add_request(QUERY_ONLY,   src_a, 48'd1101);  // one past: expired
        add_request(QUERY_ONLY,   src_b, 48'd2100);
        add_request(QUERY_RECORD, src_b, '1);        // top of the time range
        add_request(QUERY_ONLY,   src_b, '1);
        add_request(QUERY_RECORD, src_b, 48'd0);     // time steps back, no expiry
        add_request(QUERY_ONLY,   src_b, 48'd500);
        add_request(QUERY_RECORD, 32'h8000_0001, 48'h8000_0000_0000);
        add_request(QUERY_ONLY,   32'h8000_0001, 48'h8000_0000_0000);
        wait_drained();

        // Random phases over a spread of settings, extremes included.
        apply_limits(MINOR_RESET, SEVERE_RESET, PERIOD_RESET);
        queue_random_phase(150);
        wait_drained();
        apply_limits(8'd0, 8'd0, 16'd0);
        queue_random_phase(100);
        wait_drained();
        apply_limits(8'd255, 8'd255, 16'hFFFF);   // longest window, highest thresholds
        queue_random_phase(150);
        wait_drained();
        apply_limits(8'd1, 8'd3, 16'd1);
        queue_random_phase(150);
        wait_drained();
        apply_limits(8'd2, 8'd2, 16'd5);
        queue_random_phase(100);
        wait_drained();
        apply_limits(8'd3, 8'd8, 16'd0);
        queue_random_phase(100);
        wait_drained();
        repeat (4)
        begin
            apply_limits(8'($urandom_range(0, 6)), 8'($urandom_range(0, 10)),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 8)));
            queue_random_phase(100);
            wait_drained();
        end

        // Let the engine settle; a late beat would still be flagged.
        repeat (TABLE_SLOTS + 8) @(posedge clk);
        if (expected_verdicts.size() != 0)
            note_mismatch("missing beats", 0, expected_verdicts.size());
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/fsl_pkg.sv
design/fsl_ifs.sv
design/fsl_front.sv
design/fsl_queue.sv
design/fsl_back.sv
design/per_source_flood_limiter.sv
design/fsl_checker.sv
tb/sv/per_source_flood_limiter_tb.sv
